>>> sv/mtvc_pkg.sv
// Shared types, constants and helpers of the marker tracking velocity controller.
package mtvc_pkg;

	localparam logic [2:0] OP_POSE  = 3'd0;
	localparam logic [2:0] OP_CAM   = 3'd1;
	localparam logic [2:0] OP_TURN  = 3'd2;
	localparam logic [2:0] OP_SONAR = 3'd3;
	localparam logic [2:0] OP_AUTO  = 3'd4;
	localparam logic [2:0] OP_NOP   = 3'd7;

	localparam logic [1:0] TM_HOLD     = 2'd0;
	localparam logic [1:0] TM_SPIN     = 2'd1;
	localparam logic [1:0] TM_APPROACH = 2'd2;

	localparam logic [1:0] REG_KP   = 2'd0;
	localparam logic [1:0] REG_KD   = 2'd1;
	localparam logic [1:0] REG_KI   = 2'd2;
	localparam logic [1:0] REG_RATE = 2'd3;

	localparam int C_001     = 655;
	localparam int C_003     = 1966;
	localparam int C_006     = 3932;
	localparam int C_008     = 5243;
	localparam int C_010     = 6554;
	localparam int C_14      = 91750;
	localparam int SPIN_LO   = 89785;
	localparam int SPIN_HI   = 115999;
	localparam int SPIN_TURN = 13107;
	localparam int C_06      = 39322;
	localparam int C_08      = 52429;
	localparam int INT_LIM   = 1048576;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [20:0] pos_x;
		logic signed [20:0] pos_y;
		logic signed [20:0] pos_z;
		logic signed [18:0] yaw_angle;
		logic signed [18:0] pitch_angle;
		logic [15:0]        sonar_mm;
		logic [1:0]         mode_value;
	} mtvc_item_t;

	function automatic logic signed [39:0] sat_f(input logic signed [39:0] v,
			input logic signed [39:0] lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

endpackage

>>> sv/mtvc_front.sv
// Input side: decodes the request kind and queues words for the control sequencer.
module mtvc_front import mtvc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [119:0] s_axis_tdata,
	input  logic [2:0]   s_axis_tuser,
	output logic         q_valid,
	input  logic         q_ready,
	output mtvc_item_t   q_item
);

	mtvc_item_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic [2:0] op;
	logic       push, pop;

	always_comb begin
		case (s_axis_tuser)
			3'd0: op = OP_POSE;
			3'd1: op = OP_CAM;
			3'd2: op = OP_TURN;
			3'd3: op = OP_SONAR;
			3'd4: op = OP_AUTO;
			default: op = OP_NOP;
		endcase
	end

	assign s_axis_tready = (count_q != 2'd2);
	// unknown requests are taken and dropped here
	assign push = s_axis_tvalid && s_axis_tready && (op != OP_NOP);
	assign q_valid = (count_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{op: op,
				pos_x: s_axis_tdata[20:0], pos_y: s_axis_tdata[41:21],
				pos_z: s_axis_tdata[62:42], yaw_angle: s_axis_tdata[81:63],
				pitch_angle: s_axis_tdata[100:82], sonar_mm: s_axis_tdata[116:101],
				mode_value: s_axis_tdata[118:117]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");

endmodule

>>> sv/mtvc_back.sv
// Control sequencer: mode state, shared multiplier, integral divider and result register.
module mtvc_back import mtvc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  mtvc_item_t  q_item,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [17:0] cfg_data,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,
	output logic [0:0]  m_axis_tuser
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_WB   = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_INT  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	localparam logic [3:0] M_DX = 4'd0, M_DY = 4'd1, M_KPX = 4'd2, M_KDX = 4'd3;
	localparam logic [3:0] M_KPY = 4'd4, M_KDY = 4'd5, M_TURN = 4'd6, M_Z = 4'd7;
	localparam logic [3:0] M_UP = 4'd8, M_KI = 4'd9;

	logic signed [17:0] kp_q, kd_q, ki_q;
	logic [9:0]         rate_q;
	logic signed [20:0] prev_x_q, prev_y_q;
	logic signed [21:0] integral_q;
	logic signed [13:0] last_vf_q, last_vs_q;
	logic               cam_q, auto_q;
	logic [1:0]         turn_q;
	logic [15:0]        sonar_q, hold_alt_q;

	logic [2:0]         state_q;
	logic [3:0]         idx_q;
	mtvc_item_t         cur_q;
	logic               front_q, hold_q;
	logic signed [51:0] prod_q;
	logic signed [35:0] r_q [10];
	logic [11:0]        div_rem_q;
	logic [22:0]        div_dvd_q;
	logic               div_neg_q;
	logic [4:0]         div_cnt_q;

	logic               out_valid_q;
	logic signed [13:0] out_vf_q, out_vs_q;
	logic signed [11:0] out_vu_q;
	logic signed [18:0] out_tr_q;
	logic               out_upv_q, out_done_q;

	logic [10:0]        rate;
	logic signed [17:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [51:0] prod_w, rnd_w;
	logic signed [21:0] diff_x, diff_y;
	logic signed [16:0] diff_alt;
	logic               law_hold, law_spin, law_front;
	logic signed [22:0] num;
	logic [12:0]        div_tmp;
	logic [12:0]        dsor;
	logic               div_ge;
	logic signed [23:0] qstep;
	logic signed [24:0] int_sum;
	logic signed [39:0] vf_raw, vs_raw, vf_sat, vs_sat, vu_sat;
	logic signed [18:0] tr_val;
	logic               spin_in_win, fin_go;

	assign rate = (rate_q == 10'd0) ? 11'd1 : {1'b0, rate_q};
	assign diff_x = 22'(cur_q.pos_x) - 22'(prev_x_q);
	assign diff_y = 22'(cur_q.pos_y) - 22'(prev_y_q);
	assign diff_alt = $signed({1'b0, sonar_q}) - $signed({1'b0, hold_alt_q});

	assign law_hold  = cam_q && (turn_q == TM_HOLD);
	assign law_spin  = cam_q && (turn_q == TM_SPIN);
	assign law_front = !cam_q && (turn_q == TM_APPROACH);

	always_comb begin
		case (idx_q)
			M_DX:  begin mul_a = $signed({7'd0, rate}); mul_b = 34'(diff_x); end
			M_DY:  begin mul_a = $signed({7'd0, rate}); mul_b = 34'(diff_y); end
			M_KPX: begin mul_a = kp_q; mul_b = 34'(cur_q.pos_x); end
			M_KDX: begin mul_a = kd_q; mul_b = 34'(r_q[M_DX]); end
			M_KPY: begin mul_a = kp_q; mul_b = 34'(cur_q.pos_y); end
			M_KDY: begin mul_a = kd_q; mul_b = 34'(r_q[M_DY]); end
			M_TURN: begin
				mul_a = front_q ? 18'(-C_06) : 18'(-C_08);
				mul_b = front_q ? 34'(cur_q.pitch_angle) : 34'(cur_q.yaw_angle);
			end
			M_Z:   begin mul_a = 18'(C_010); mul_b = 34'(cur_q.pos_z); end
			M_UP:  begin mul_a = 18'(-C_001); mul_b = 34'(diff_alt); end
			M_KI:  begin mul_a = ki_q; mul_b = 34'(integral_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign prod_w = mul_a * mul_b;
	// round to nearest, ties up
	assign rnd_w = prod_q + 52'sd32768;

	assign num = $signed({cur_q.pos_x[20], cur_q.pos_x, 1'b0}) + $signed({12'd0, rate});
	assign dsor = {1'b0, rate, 1'b0};
	assign div_tmp = {div_rem_q, div_dvd_q[22]};
	assign div_ge = (div_tmp >= dsor);
	// floor division: round a negative quotient away from zero on a remainder
	assign qstep = div_neg_q ? -($signed({1'b0, div_dvd_q}) + 24'(div_rem_q != 12'd0))
	                         : $signed({1'b0, div_dvd_q});
	assign int_sum = 25'(integral_q) + 25'(qstep);

	assign spin_in_win = (cur_q.yaw_angle > SPIN_LO) && (cur_q.yaw_angle < SPIN_HI);

	always_comb begin
		vu_sat = '0;
		if (front_q) begin
			if (cur_q.pos_x > 0)
				vs_raw = 40'(r_q[M_KDX]) - 40'(r_q[M_KPX]) - 40'(C_001) + 40'(r_q[M_KI]);
			else if (cur_q.pos_x < 0)
				vs_raw = 40'(r_q[M_KDX]) - 40'(r_q[M_KPX]) - 40'(C_001);
			else
				vs_raw = '0;
			if (cur_q.pos_z < C_14) vf_raw = -40'(r_q[M_Z]);
			else if (cur_q.pos_z > C_14) vf_raw = 40'(r_q[M_Z]);
			else vf_raw = '0;
			tr_val = 19'(r_q[M_TURN]);
			vu_sat = sat_f(40'(r_q[M_UP]), 40'(C_003));
			vf_sat = sat_f(vf_raw, 40'(C_003));
			vs_sat = sat_f(vs_raw, 40'(C_008));
		end else begin
			if (cur_q.pos_y > 0)
				vf_raw = 40'(r_q[M_KDY]) - 40'(r_q[M_KPY]) - 40'(C_001);
			else if (cur_q.pos_y < 0)
				vf_raw = 40'(r_q[M_KDY]) - 40'(r_q[M_KPY]) + 40'(C_001);
			else
				vf_raw = hold_q ? '0 : 40'(last_vf_q);
			if (cur_q.pos_x > 0)
				vs_raw = 40'(r_q[M_KDX]) - 40'(r_q[M_KPX]) - 40'(C_001);
			else if (cur_q.pos_x < 0)
				vs_raw = 40'(r_q[M_KDX]) - 40'(r_q[M_KPX]) + 40'(C_001);
			else
				vs_raw = hold_q ? '0 : 40'(last_vs_q);
			if (hold_q) tr_val = 19'(r_q[M_TURN]);
			else if (cur_q.yaw_angle > SPIN_HI) tr_val = 19'(-SPIN_TURN);
			else if (cur_q.yaw_angle < SPIN_LO) tr_val = 19'(SPIN_TURN);
			else tr_val = '0;
			vf_sat = sat_f(vf_raw, 40'(C_006));
			vs_sat = sat_f(vs_raw, 40'(C_006));
		end
	end

	assign q_ready = (state_q == ST_IDLE);
	assign fin_go = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) cur_q <= q_item;
		if (state_q == ST_MUL) prod_q <= prod_w;
		if (state_q == ST_WB) begin
			if (idx_q == M_DX || idx_q == M_DY || idx_q == M_UP)
				r_q[idx_q] <= prod_q[35:0];
			else
				r_q[idx_q] <= rnd_w[51:16];
		end
		if (state_q == ST_WB && idx_q == M_UP) begin
			div_rem_q <= '0;
			div_dvd_q <= (num < 0) ? 23'(-num) : 23'(num);
			div_neg_q <= (num < 0);
		end else if (state_q == ST_DIV) begin
			div_rem_q <= div_ge ? 12'(div_tmp - dsor) : div_tmp[11:0];
			div_dvd_q <= {div_dvd_q[21:0], div_ge};
		end
		if (fin_go) begin
			out_vf_q   <= vf_sat[13:0];
			out_vs_q   <= vs_sat[13:0];
			out_vu_q   <= vu_sat[11:0];
			out_tr_q   <= tr_val;
			out_upv_q  <= front_q;
			out_done_q <= !front_q && !hold_q && spin_in_win;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= 18'sd6554;
			kd_q        <= -18'sd1966;
			ki_q        <= 18'sd655;
			rate_q      <= 10'd100;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			integral_q  <= '0;
			last_vf_q   <= '0;
			last_vs_q   <= '0;
			cam_q       <= 1'b0;
			auto_q      <= 1'b0;
			turn_q      <= TM_HOLD;
			sonar_q     <= '0;
			hold_alt_q  <= '0;
			state_q     <= ST_IDLE;
			idx_q       <= M_DX;
			front_q     <= 1'b0;
			hold_q      <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_KP:   kp_q <= cfg_data;
					REG_KD:   kd_q <= cfg_data;
					REG_KI:   ki_q <= cfg_data;
					REG_RATE: rate_q <= cfg_data[9:0];
					default:  ;
				endcase
			end
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						case (q_item.op)
							OP_CAM:   cam_q <= ~cam_q;
							OP_TURN:  turn_q <= q_item.mode_value;
							OP_SONAR: sonar_q <= q_item.sonar_mm;
							OP_AUTO:  auto_q <= (q_item.mode_value != 2'd0);
							OP_POSE: begin
								if (!auto_q && (law_hold || law_spin || law_front)) begin
									front_q <= law_front;
									hold_q  <= law_hold;
									idx_q   <= M_DX;
									state_q <= ST_MUL;
								end
							end
							default: ;
						endcase
					end
				end
				ST_MUL: state_q <= ST_WB;
				ST_WB: begin
					if (idx_q == M_UP) begin
						if (front_q) begin
							div_cnt_q <= '0;
							state_q   <= ST_DIV;
						end else begin
							state_q <= ST_FIN;
						end
					end else if (idx_q == M_KI) begin
						state_q <= ST_FIN;
					end else begin
						idx_q   <= idx_q + 4'd1;
						state_q <= ST_MUL;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd22) state_q <= ST_INT;
				end
				ST_INT: begin
					integral_q <= 22'(sat_f(40'(int_sum), 40'(INT_LIM)));
					idx_q      <= M_KI;
					state_q    <= ST_MUL;
				end
				ST_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						prev_x_q    <= cur_q.pos_x;
						prev_y_q    <= cur_q.pos_y;
						last_vf_q   <= vf_sat[13:0];
						last_vs_q   <= vs_sat[13:0];
						if (hold_q) hold_alt_q <= sonar_q;
						if (!front_q && !hold_q && spin_in_win) turn_q <= TM_APPROACH;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'd0, out_done_q, out_tr_q, out_vu_q, out_vs_q, out_vf_q};
	assign m_axis_tuser = out_upv_q;

	a_int_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(integral_q <= INT_LIM) && (integral_q >= -INT_LIM))
		else $error("integral outside its limit");
	a_done_not_front: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_done_q |-> !out_upv_q)
		else $error("spin done raised in approach");
	a_last_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(last_vf_q <= C_008) && (last_vf_q >= -C_008))
		else $error("stored forward command out of range");
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) && out_valid_q && !m_axis_tready |=> (state_q == ST_FIN))
		else $error("result overwritten while stalled");

endmodule

>>> sv/marker_tracking_velocity_controller.sv
// Top level of the marker tracking velocity controller.
// Input stream: s_axis words carry either a marker pose or an event (camera toggle,
// turn mode, sonar altitude, auto flag); tuser gives the request kind. Events update
// mode state and produce no output. A pose produces one velocity word on m_axis when
// a control law is active (manual mode and a matching camera/turn mode), else none.
// Gains and the sample rate are written through the cfg channel; the user must write
// them only while the block is idle, which the block itself does not enforce. In the
// sequencer an event is handled in the idle state. A pose in bottom hold or spin passes
// through the input queue, a dispatch step, nine products on one shared multiplier
// (each a multiply step and a write-back step) and a result step before its word shows.
// In front approach the 23-step integral divider, an integral update step and one more
// product are added. Items are processed one at a time; a 2-word queue at the input
// lets new words arrive while the sequencer works.
// Reset: gains return to their defaults, all tracking state clears, camera is front,
// turn mode is hold. If the receiver stalls, the result register holds its word, the
// sequencer waits at its final step, and the input queue fills and then deasserts tready.
module marker_tracking_velocity_controller import mtvc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pos_x[20:0], pos_y[41:21], pos_z[62:42], yaw_angle[81:63], pitch_angle[100:82],
	// sonar_mm[116:101], mode_value[118:117]
	input  logic [119:0] s_axis_tdata,
	// req_type[2:0]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// vel_fwd[13:0], vel_side[27:14], vel_up[39:28], turn_rate[58:40], spin_done[59]
	output logic [63:0]  m_axis_tdata,
	// vel_up_valid[0]
	output logic [0:0]   m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [17:0]  cfg_data
);

	logic       q_valid, q_ready;
	mtvc_item_t q_item;

	assign cfg_ready = 1'b1;

	mtvc_front u_front (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
		.q_valid, .q_ready, .q_item
	);

	mtvc_back u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_item,
		.cfg_valid, .cfg_index, .cfg_data,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
	);

endmodule

>>> test/marker_tracking_velocity_controller_tb.sv
// Self-checking testbench of the marker tracking velocity controller.
`timescale 1ns / 100ps

module marker_tracking_velocity_controller_tb;
	import mtvc_pkg::*;

	typedef struct packed {
		logic signed [13:0] fwd;
		logic signed [13:0] side;
		logic signed [11:0] up;
		logic               up_valid;
		logic signed [18:0] turn;
		logic               done;
	} velocity_t;

	// directed rows; has_fixed marks a result typed in by hand
	typedef struct {
		mtvc_item_t item;
		bit         has_fixed;
		velocity_t  fixed;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata = '0;
	logic [2:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [63:0]  m_axis_tdata;
	logic [0:0]   m_axis_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [17:0]  cfg_data = '0;

	marker_tracking_velocity_controller dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("marker_tracking_velocity_controller_tb: done, errors");
		$finish;
	end

	// predictor state
	longint kp, kd, ki, rate_hz;
	longint px, py, integ, last_fwd, last_side;
	bit     bot_cam, auto_on;
	logic [1:0] tmode;
	longint sonar, hold_alt;

	velocity_t vel_q[$];
	int  n_err = 0;
	bit  quiet = 1'b0;

	function automatic longint div_up(longint n, longint d);
		if (n >= 0) return n / d;
		return -((-n + d - 1) / d);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return div_up(a * b + 32768, 65536);
	endfunction

	function automatic longint clip(longint v, longint lim);
		return v > lim ? lim : (v < -lim ? -lim : v);
	endfunction

	function automatic longint lateral(longint p, longint d);
		longint v;
		v = -qmul(kp, p) + qmul(kd, d);
		return p > 0 ? v - C_001 : v + C_001;
	endfunction

	task automatic reset_predictor();
		kp = 6554; kd = -1966; ki = 655; rate_hz = 100;
		px = 0; py = 0; integ = 0; last_fwd = 0; last_side = 0;
		bot_cam = 0; auto_on = 0; tmode = TM_HOLD; sonar = 0; hold_alt = 0;
	endtask

	// returns 1 and the command when the pose runs a law
	function automatic bit predict_velocity(mtvc_item_t it, output velocity_t v);
		longint x, y, z, yaw, pitch, r, dx, dy, vf, vs, vu, tr;
		bit hold, spin, front, dn;
		v = '0;
		case (it.op)
			OP_CAM:   begin bot_cam = ~bot_cam; return 0; end
			OP_TURN:  begin tmode = it.mode_value; return 0; end
			OP_SONAR: begin sonar = it.sonar_mm; return 0; end
			OP_AUTO:  begin auto_on = it.mode_value != 0; return 0; end
			default: ;
		endcase
		if (it.op != OP_POSE || auto_on) return 0;
		hold = bot_cam && tmode == TM_HOLD;
		spin = bot_cam && tmode == TM_SPIN;
		front = !bot_cam && tmode == TM_APPROACH;
		if (!hold && !spin && !front) return 0;
		x = it.pos_x; y = it.pos_y; z = it.pos_z;
		yaw = it.yaw_angle; pitch = it.pitch_angle;
		r = rate_hz ? rate_hz : 1;
		dx = (x - px) * r; dy = (y - py) * r;
		px = x; py = y;
		vu = 0; dn = 0;
		if (front) begin
			integ = clip(integ + div_up(2 * x + r, 2 * r), INT_LIM);
			if (x > 0) vs = -qmul(kp, x) + qmul(kd, dx) - C_001 + qmul(ki, integ);
			else if (x < 0) vs = -qmul(kp, x) + qmul(kd, dx) - C_001;
			else vs = 0;
			if (z < C_14) vf = -qmul(C_010, z);
			else if (z > C_14) vf = qmul(C_010, z);
			else vf = 0;
			tr = qmul(-C_06, pitch);
			vu = clip(-C_001 * (sonar - hold_alt), C_003);
			vf = clip(vf, C_003);
			vs = clip(vs, C_008);
		end else begin
			vf = y != 0 ? lateral(y, dy) : (hold ? 0 : last_fwd);
			vs = x != 0 ? lateral(x, dx) : (hold ? 0 : last_side);
			if (hold) tr = qmul(-C_08, yaw);
			else if (yaw > SPIN_HI) tr = -SPIN_TURN;
			else if (yaw < SPIN_LO) tr = SPIN_TURN;
			else tr = 0;
			vf = clip(vf, C_006);
			vs = clip(vs, C_006);
			if (hold) hold_alt = sonar;
			if (spin && yaw > SPIN_LO && yaw < SPIN_HI) begin
				tmode = TM_APPROACH;
				dn = 1;
			end
		end
		last_fwd = vf; last_side = vs;
		v.fwd = 14'(vf); v.side = 14'(vs); v.up = 12'(vu); v.up_valid = front;
		v.turn = 19'(tr); v.done = dn;
		return 1;
	endfunction

	// result checker
	always @(posedge clk) begin
		velocity_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.fwd = m_axis_tdata[13:0];
			got.side = m_axis_tdata[27:14];
			got.up = m_axis_tdata[39:28];
			got.turn = m_axis_tdata[58:40];
			got.done = m_axis_tdata[59];
			got.up_valid = m_axis_tuser[0];
			if (vel_q.size() == 0) begin
				$error("unexpected velocity word");
				n_err++;
			end else begin
				want = vel_q.pop_front();
				if (got.fwd !== want.fwd) begin
					$error("vel_fwd exp %0d got %0d", want.fwd, got.fwd); n_err++;
				end
				if (got.side !== want.side) begin
					$error("vel_side exp %0d got %0d", want.side, got.side); n_err++;
				end
				if (got.up !== want.up) begin
					$error("vel_up exp %0d got %0d", want.up, got.up); n_err++;
				end
				if (got.up_valid !== want.up_valid) begin
					$error("vel_up_valid exp %0b got %0b", want.up_valid, got.up_valid);
					n_err++;
				end
				if (got.turn !== want.turn) begin
					$error("turn_rate exp %0d got %0d", want.turn, got.turn); n_err++;
				end
				if (got.done !== want.done) begin
					$error("spin_done exp %0b got %0b", want.done, got.done); n_err++;
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 15);
	end

	task automatic send_word(mtvc_item_t it, bit has_fixed, velocity_t fixed);
		velocity_t v;
		bit hit;
		while (!quiet && $urandom_range(99) < 15) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.op;
		s_axis_tdata <= {1'b0, it.mode_value, it.sonar_mm, it.pitch_angle, it.yaw_angle,
			it.pos_z, it.pos_y, it.pos_x};
		do @(posedge clk); while (!s_axis_tready);
		hit = predict_velocity(it, v);
		if (hit) vel_q.push_back(has_fixed ? fixed : v);
	endtask

	task automatic drain();
		int guard;
		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (vel_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [17:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_KP:   kp = longint'($signed(val));
			REG_KD:   kd = longint'($signed(val));
			REG_KI:   ki = longint'($signed(val));
			REG_RATE: rate_hz = val[9:0];
			default: ;
		endcase
	endtask

	function automatic mtvc_item_t make_item(logic [2:0] op, int x, int y, int z,
			int yaw, int pitch, int son, int md);
		mtvc_item_t it;
		it.op = op; it.pos_x = 21'(x); it.pos_y = 21'(y); it.pos_z = 21'(z);
		it.yaw_angle = 19'(yaw); it.pitch_angle = 19'(pitch);
		it.sonar_mm = 16'(son); it.mode_value = 2'(md);
		return it;
	endfunction

	function automatic int rnd_pos();
		case ($urandom_range(5))
			0: return 0;
			1: return $urandom_range(1) ? 524288 : -524288;
			2: return $signed($urandom_range(2097151) << 11) >>> 11;
			default: return int'($urandom_range(40000)) - 20000;
		endcase
	endfunction

	function automatic int rnd_angle();
		case ($urandom_range(4))
			0: return $urandom_range(1) ? 205887 : -205887;
			1: return $urandom_range(SPIN_LO - 5, SPIN_HI + 5);
			2: return $signed($urandom_range(524287) << 13) >>> 13;
			default: return int'($urandom_range(411774)) - 205887;
		endcase
	endfunction

	function automatic mtvc_item_t rnd_pose();
		return make_item(OP_POSE, rnd_pos(), rnd_pos(), $urandom_range(3) == 0 ? C_14 : rnd_pos(),
			rnd_angle(), rnd_angle(), 0, $urandom_range(3));
	endfunction

	task automatic run_random(int n);
		mtvc_item_t it;
		velocity_t none;
		int k;
		none = '0;
		for (k = 0; k < n; k++) begin
			if (k == n / 2) quiet = 1'b1;
			if (k == n / 2 + 40) quiet = 1'b0;
			// sender pauses until all results are back
			if (k == n / 3) drain();
			case ($urandom_range(19))
				0: it = make_item(OP_CAM, rnd_pos(), 0, 0, 0, 0, 0, 0);
				1: it = make_item(OP_TURN, 0, 0, 0, 0, 0, 0, $urandom_range(3));
				2, 3: it = make_item(OP_SONAR, 0, 0, 0, 0, 0, $urandom_range(65535), 0);
				4: it = make_item(OP_AUTO, 0, 0, 0, 0, 0, 0,
					$urandom_range(3) == 0 ? $urandom_range(3) : 0);
				5: it = make_item(3'($urandom_range(7, 5)), rnd_pos(), 0, 0, 0, 0,
					$urandom_range(65535), $urandom_range(3));
				default: it = rnd_pose();
			endcase
			// steer toward active laws most of the time
			if (it.op == OP_POSE && $urandom_range(3) != 0) begin
				if (auto_on) send_word(make_item(OP_AUTO, 0, 0, 0, 0, 0, 0, 0), 0, none);
				if (!(bot_cam ? tmode inside {TM_HOLD, TM_SPIN} : tmode == TM_APPROACH)) begin
					if ($urandom_range(1)) send_word(make_item(OP_CAM, 0, 0, 0, 0, 0, 0, 0), 0, none);
					send_word(make_item(OP_TURN, 0, 0, 0, 0, 0, 0,
						bot_cam ? $urandom_range(1) : TM_APPROACH), 0, none);
				end
			end
			send_word(it, 0, none);
		end
	endtask

	stim_row_t rows[$];
	velocity_t zv;

	initial begin
		reset_predictor();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		zv = '0;
		// front camera, hold mode after reset: pose gives nothing
		rows.push_back('{make_item(OP_POSE, 100, 100, 0, 0, 0, 0, 0), 0, zv});
		rows.push_back('{make_item(OP_CAM, 0, 0, 0, 0, 0, 0, 0), 0, zv});
		// bottom hold, zero position: only turn from yaw, zero yaw gives zero
		rows.push_back('{make_item(OP_POSE, 0, 0, 0, 0, 0, 0, 0), 1, zv});
		rows.push_back('{make_item(OP_SONAR, 0, 0, 0, 0, 0, 65535, 0), 0, zv});
		rows.push_back('{make_item(OP_POSE, 524288, -524288, 524288, 205887, -205887, 0, 0),
			0, zv});
		rows.push_back('{make_item(OP_POSE, -524288, 524288, -524288, -205887, 205887, 0, 0),
			0, zv});
		rows.push_back('{make_item(OP_TURN, 0, 0, 0, 0, 0, 0, TM_SPIN), 0, zv});
		rows.push_back('{make_item(OP_POSE, 1000, 0, 0, 0, 0, 0, 0), 0, zv});
		// zero position keeps last command in spin
		rows.push_back('{make_item(OP_POSE, 0, 0, 0, 205887, 0, 0, 0), 0, zv});
		rows.push_back('{make_item(OP_POSE, 5, 5, 0, SPIN_HI, 0, 0, 0), 0, zv});
		// yaw inside the window finishes the spin
		rows.push_back('{make_item(OP_POSE, -5, -5, 0, 102943, 0, 0, 0), 0, zv});
		rows.push_back('{make_item(OP_POSE, 0, 0, 0, 0, 0, 0, 0), 0, zv});
		rows.push_back('{make_item(OP_CAM, 0, 0, 0, 0, 0, 0, 0), 0, zv});
		rows.push_back('{make_item(OP_SONAR, 0, 0, 0, 0, 0, 0, 0), 0, zv});
		// front approach: positive x, negative x, z at the 1.4 threshold
		rows.push_back('{make_item(OP_POSE, 524288, 3, C_14, 0, 205887, 0, 0), 0, zv});
		rows.push_back('{make_item(OP_POSE, -524288, 3, 524288, 0, -205887, 0, 0), 0, zv});
		rows.push_back('{make_item(OP_POSE, 0, 0, -524288, 0, 0, 0, 0), 0, zv});
		rows.push_back('{make_item(OP_AUTO, 0, 0, 0, 0, 0, 0, 2), 0, zv});
		rows.push_back('{make_item(OP_POSE, 7, 7, 7, 7, 7, 0, 0), 0, zv});
		rows.push_back('{make_item(OP_AUTO, 0, 0, 0, 0, 0, 0, 0), 0, zv});
		rows.push_back('{make_item(OP_NOP, 7, 7, 7, 7, 7, 65535, 3), 0, zv});
		rows.push_back('{make_item(OP_TURN, 0, 0, 0, 0, 0, 0, 3), 0, zv});
		rows.push_back('{make_item(OP_POSE, 9, 9, 9, 9, 9, 0, 0), 0, zv});
		rows.push_back('{make_item(OP_TURN, 0, 0, 0, 0, 0, 0, TM_APPROACH), 0, zv});
		rows.push_back('{make_item(OP_POSE, 300, 0, 0, 0, 0, 0, 0), 0, zv});
		foreach (rows[i]) send_word(rows[i].item, rows[i].has_fixed, rows[i].fixed);

		drain();
		write_reg(REG_KP, 18'sd65536);
		write_reg(REG_KD, -18'sd65536);
		write_reg(REG_KI, 18'sd65536);
		write_reg(REG_RATE, 10'd1000);
		run_random(140);

		drain();
		write_reg(REG_KP, -18'sd65536);
		write_reg(REG_KD, 18'sd65536);
		write_reg(REG_KI, -18'sd65536);
		write_reg(REG_RATE, 10'd0);
		run_random(130);

		drain();
		write_reg(REG_KP, 18'($urandom_range(131072) - 65536));
		write_reg(REG_KD, 18'($urandom_range(131072) - 65536));
		write_reg(REG_KI, 18'($urandom_range(131072) - 65536));
		write_reg(REG_RATE, 10'd1);
		run_random(130);

		drain();
		write_reg(REG_KP, 18'd6554);
		write_reg(REG_KD, -18'sd1966);
		write_reg(REG_KI, 18'd655);
		write_reg(REG_RATE, 10'd100);
		run_random(130);

		drain();
		if (n_err == 0 && vel_q.size() == 0)
			$display("marker_tracking_velocity_controller_tb: done, clean");
		else
			$display("marker_tracking_velocity_controller_tb: done, errors");
		$finish;
	end

endmodule
